FILE: rtl/efp_pkg.sv
// shared types and constants for the envelope frame parser
`default_nettype none

package efp_pkg;

    // header layout, little-endian, 24 bytes
    localparam int HDR_BYTES     = 24;
    localparam int HDR_BITS      = HDR_BYTES * 8;
    localparam int HDR_POS_W     = 5;
    localparam int MAGIC_LSB     = 0;
    localparam int VERSION_LSB   = 32;
    localparam int FLAGS_LSB     = 48;
    localparam int KIND_LSB      = 64;
    localparam int TAG_LSB       = 96;
    localparam int LENGTH_LSB    = 160;

    // result tdata packing, lowest bit up
    localparam int OUT_STATUS_LSB = 8;
    localparam int OUT_FIELDS_W   = 170;
    localparam int OUT_TDATA_W    = 176;

    // configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_MAGIC   = 2'd0,
        REG_VERSION = 2'd1,
        REG_LIMIT   = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_PARSE_FAIL  = 2'd1,
        STATUS_BAD_VERSION = 2'd2,
        STATUS_INVALID     = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] expected_magic;
        logic [15:0] expected_version;
        logic [31:0] payload_limit;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic        frame_done;
        status_t     status;
        logic [31:0] message_kind;
        logic [15:0] header_flags;
        logic [63:0] request_tag;
        logic [15:0] schema_seen;
        logic [31:0] payload_length;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/efp_regs.sv
// apb configuration registers: magic, version, payload limit
`default_nettype none

module efp_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [efp_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [efp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [efp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    output efp_pkg::cfg_t                       cfg
);
    import efp_pkg::*;

    logic [31:0] magic_reg;
    logic [15:0] version_reg;
    logic [31:0] limit_reg;
    logic        wr_en;
    logic [1:0]  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    // register writes on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg   <= 32'd0;
            version_reg <= 16'd1;
            limit_reg   <= 32'd65536;
        end else if (wr_en) begin
            case (reg_sel)
                REG_MAGIC:   magic_reg   <= pwdata;
                REG_VERSION: version_reg <= pwdata[15:0];
                REG_LIMIT:   limit_reg   <= pwdata;
                default:     ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_sel)
            REG_MAGIC:   prdata = magic_reg;
            REG_VERSION: prdata = {16'd0, version_reg};
            REG_LIMIT:   prdata = limit_reg;
            default:     prdata = '0;
        endcase
    end

    assign cfg.expected_magic   = magic_reg;
    assign cfg.expected_version = version_reg;
    assign cfg.payload_limit    = limit_reg;

endmodule

`default_nettype wire

FILE: rtl/efp_core.sv
// frame state: header assembly, header checks, payload count, status
`default_nettype none

module efp_core #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire efp_pkg::cfg_t cfg,
    input  wire logic          step,
    input  wire logic [7:0]    data_byte,
    input  wire logic          end_of_message,
    output logic               res_valid,
    output efp_pkg::result_t   res
);
    import efp_pkg::*;

    localparam logic [HDR_POS_W-1:0] POS_FULL = HDR_POS_W'(HDR_BYTES);

    logic [HDR_POS_W-1:0]   pos_reg, pos_next;
    logic [HDR_BITS-1:0]    hdr_reg, hdr_next;
    logic [LENGTH_BITS-1:0] seen_reg, seen_next;
    status_t                err_reg, err_next;
    status_t                chk_code;
    status_t                final_status;
    logic                   byte_ok;

    logic [31:0] magic_n, kind_n, length_n;
    logic [15:0] version_n, flags_n;
    logic [63:0] tag_n;

    // header fields as they stand after this byte
    assign magic_n   = hdr_next[MAGIC_LSB   +: 32];
    assign version_n = hdr_next[VERSION_LSB +: 16];
    assign flags_n   = hdr_next[FLAGS_LSB   +: 16];
    assign kind_n    = hdr_next[KIND_LSB    +: 32];
    assign tag_n     = hdr_next[TAG_LSB     +: 64];
    assign length_n  = hdr_next[LENGTH_LSB  +: 32];

    // header checks in order of precedence
    always_comb begin
        if (magic_n != cfg.expected_magic)
            chk_code = STATUS_PARSE_FAIL;
        else if (version_n != cfg.expected_version)
            chk_code = STATUS_BAD_VERSION;
        else if (kind_n == 32'd0 || length_n > cfg.payload_limit ||
                 (length_n >> LENGTH_BITS) != 32'd0)
            chk_code = STATUS_INVALID;
        else
            chk_code = STATUS_OK;
    end

    // next frame state for this byte
    always_comb begin
        pos_next  = pos_reg;
        hdr_next  = hdr_reg;
        seen_next = seen_reg;
        err_next  = err_reg;
        byte_ok   = 1'b0;
        if (pos_reg != POS_FULL) begin
            hdr_next[{pos_reg, 3'b000} +: 8] = data_byte;
            pos_next = pos_reg + HDR_POS_W'(1);
        end else if (err_reg == STATUS_OK) begin
            if (32'(seen_reg) < hdr_reg[LENGTH_LSB +: 32]) begin
                seen_next = seen_reg + LENGTH_BITS'(1);
                byte_ok   = 1'b1;
            end else begin
                err_next = STATUS_PARSE_FAIL;
            end
        end
        if (pos_reg != POS_FULL && pos_next == POS_FULL)
            err_next = chk_code;
    end

    // status on the final byte
    always_comb begin
        if (pos_next != POS_FULL)
            final_status = STATUS_PARSE_FAIL;
        else if (err_next != STATUS_OK)
            final_status = err_next;
        else if (32'(seen_next) != length_n)
            final_status = STATUS_PARSE_FAIL;
        else
            final_status = STATUS_OK;
    end

    // result item, fields zero where they carry nothing
    always_comb begin
        res = '0;
        res.payload_byte = byte_ok ? data_byte : 8'd0;
        res.byte_valid   = byte_ok;
        if (end_of_message) begin
            res.frame_done     = 1'b1;
            res.status         = final_status;
            res.message_kind   = kind_n;
            res.header_flags   = flags_n;
            res.request_tag    = tag_n;
            res.schema_seen    = version_n;
            res.payload_length = length_n;
        end
    end

    assign res_valid = step && (byte_ok || end_of_message);

    // frame state, cleared after the final byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            hdr_reg  <= '0;
            seen_reg <= '0;
            err_reg  <= STATUS_OK;
        end else if (step) begin
            if (end_of_message) begin
                pos_reg  <= '0;
                hdr_reg  <= '0;
                seen_reg <= '0;
                err_reg  <= STATUS_OK;
            end else begin
                pos_reg  <= pos_next;
                hdr_reg  <= hdr_next;
                seen_reg <= seen_next;
                err_reg  <= err_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/efp_outreg.sv
// result register and stream packing for the master side
`default_nettype none

module efp_outreg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    input  wire efp_pkg::result_t                in_res,
    output logic                                 in_ready,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [efp_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                                 m_tuser,
    output logic                                 m_tlast
);
    import efp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // free when empty or when the held transaction leaves this cycle
    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            res_reg <= in_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.byte_valid;
    assign m_tlast  = res_reg.frame_done;
    assign m_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0),
                       res_reg.payload_length,
                       res_reg.schema_seen,
                       res_reg.request_tag,
                       res_reg.header_flags,
                       res_reg.message_kind,
                       res_reg.status,
                       res_reg.payload_byte};

endmodule

`default_nettype wire

FILE: rtl/envelope_frame_parser.sv
// top level of the envelope frame parser
//
// Parses a byte stream of framed messages. Slave side: one byte per
// transaction on s_tdata, s_tlast on the final byte of a message. The first
// 24 bytes form the header (magic, version, flags, type, request id,
// payload length); it is checked against the APB registers when complete.
// Master side: a transaction for each passed payload byte (m_tuser high)
// and one for the final byte (m_tlast high) carrying status and header
// fields. Header bytes and dropped payload bytes give no transaction.
// Downstream drops the payload of a frame whose final status is not ok.
// A result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the receiver stalls; each step is one
// pass through the header update and check logic into the result register.
// When the receiver stalls, a held result stays in place and s_tready is
// low until it leaves; an empty result register keeps s_tready high.
// Reset (aresetn low, synchronous) empties the result register, clears the
// frame state and loads magic 0, version 1, payload limit 65536.
`default_nettype none

module envelope_frame_parser #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // apb configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [efp_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [efp_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [efp_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready,
    // input bytes
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,  // data_byte
    input  wire logic                            s_tlast,  // end_of_message
    // results
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // payload_byte[7:0], status[9:8], message_kind[41:10],
    // header_flags[57:42], request_tag[121:58], schema_seen[137:122],
    // payload_length[169:138], zero fill
    output logic      [efp_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                                 m_tuser,  // byte_valid
    output logic                                 m_tlast   // frame_done
);
    import efp_pkg::*;

    cfg_t    cfg;
    result_t core_res;
    logic    core_valid;
    logic    step;

    assign step = s_tvalid && s_tready;

    // configuration registers
    efp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // frame parsing
    efp_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .step           (step),
        .data_byte      (s_tdata),
        .end_of_message (s_tlast),
        .res_valid      (core_valid),
        .res            (core_res)
    );

    // result register
    efp_outreg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (core_valid),
        .in_res   (core_res),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/efp_checker.sv
// port-level checks for the envelope frame parser, bound to the top level
`default_nettype none

module efp_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [efp_pkg::OUT_TDATA_W-1:0] m_tdata,
    input wire logic                            m_tuser,
    input wire logic                            m_tlast
);
    import efp_pkg::*;

    // a stalled result transaction holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
        $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // every result carries a payload byte or closes a frame
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser || m_tlast)
        else $error("result with neither payload byte nor frame end");

    // status and header fields are zero except on the frame end
    a_mid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[OUT_FIELDS_W-1:OUT_STATUS_LSB] == '0)
        else $error("header fields shown before frame end");

    // no new byte is taken while a full result register is stalled
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while result stalled");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind envelope_frame_parser efp_checker u_efp_checker (.*);

`default_nettype wire
